>>> rtl/ilws_pkg.sv
// ----------------------------------------------------------------------------
// ilws_pkg
// shared sizes, codes, types and helpers of the indexed list with shift
// ----------------------------------------------------------------------------
package ilws_pkg;

   // list geometry
   localparam int DEPTH = 16;
   localparam int WIDTH = 32;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W = $clog2(DEPTH + 1);
   // compare width for index resolution: holds a magnitude of 32 and any length
   localparam int CW    = ((LEN_W > 6) ? LEN_W : 6) + 1;

   // word layouts
   localparam int IDX_W       = 6;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_STAT_LSB  = 0;
   localparam int RSP_READ_LSB  = 2;
   localparam int RSP_COUNT_LSB = 34;

   typedef enum logic [2:0] {
      OP_GET    = 3'd0,
      OP_SET    = 3'd1,
      OP_APPEND = 3'd2,
      OP_INSERT = 3'd3,
      OP_REMOVE = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             ok;
      logic [LEN_W-1:0] pos;
   } resolve_type;

   function automatic logic [WIDTH-1:0] fit_entry(input logic [31:0] v);
      logic [95:0] t;
      t = {64'd0, v};
      return t[WIDTH-1:0];
   endfunction

   function automatic logic [31:0] fit_word(input logic [WIDTH-1:0] e);
      logic [WIDTH+31:0] t;
      t = {32'd0, e};
      return t[31:0];
   endfunction

   function automatic logic [4:0] fit_count(input logic [LEN_W-1:0] n);
      logic [LEN_W+4:0] t;
      t = {5'd0, n};
      return t[4:0];
   endfunction

endpackage

>>> rtl/ilws_ram.sv
// ----------------------------------------------------------------------------
// ilws_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ilws_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [DATA_W-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [DATA_W-1:0]                      rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ilws_resolve.sv
// ----------------------------------------------------------------------------
// ilws_resolve
// turns a signed list index into a position and checks it against the length
// ----------------------------------------------------------------------------
module ilws_resolve (
   input  logic [ilws_pkg::IDX_W-1:0] idx,
   input  logic [ilws_pkg::LEN_W-1:0] length,
   input  logic                       allow_end,
   output ilws_pkg::resolve_type      res
);
   import ilws_pkg::*;

   logic [IDX_W-1:0] mag;
   logic [CW-1:0]    mag_w;
   logic [CW-1:0]    len_w;
   logic [CW-1:0]    fwd_w;
   logic [CW-1:0]    back_pos;

   always_comb begin
      // magnitude of a negative index, 1 to 32
      mag      = ~idx + IDX_W'(1);
      mag_w    = CW'(mag);
      len_w    = CW'(length);
      fwd_w    = CW'(idx[IDX_W-2:0]);
      back_pos = len_w - mag_w;
      if (idx[IDX_W-1]) begin
         res.ok  = (mag_w <= len_w);
         res.pos = back_pos[LEN_W-1:0];
      end else begin
         res.ok  = (fwd_w < len_w) || (allow_end && (fwd_w == len_w));
         res.pos = fwd_w[LEN_W-1:0];
      end
   end

endmodule

>>> rtl/indexed_list_with_shift.sv
// ----------------------------------------------------------------------------
// indexed_list_with_shift
// ordered list of entries with get, set, append, insert, remove and clear
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to DEPTH entries in a single ram with
// one write port and one registered read port. A request word carries an
// operation in tuser and an index and a value in tdata; a negative index counts
// back from the end of the list, so -1 names the last entry. Each request gives
// exactly one response word with a status, the entry read by get (zero
// otherwise) and the list length after the operation. A bad index or a full
// list gives a status code and leaves the list untouched. One request is worked
// at a time and req_tready is low meanwhile. Set, append, clear, unused codes
// and every refused request go from decode straight to finish, get passes
// through a read state for the registered ram read. Insert moves length -
// position entries and remove length - position - 1; they move one at a time
// through the single ram port pair, a read in one cycle and a write in the
// next, stepped by one shared neighbor step and end test. A finished response
// sits in an output register, so the next request is taken while it waits.
// There is no clearing pass after reset: entries are only read after they were
// written.
module indexed_list_with_shift (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, from bit 0 up: index (6, signed), value (32), zero fill
   input  logic [ilws_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser, from bit 0 up: op (3)
   input  logic [ilws_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, from bit 0 up: status (2), read_value (32), count (5), zero fill
   output logic [ilws_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ilws_pkg::*;

   // sequencer state
   state_type state_ff, state_in;

   // latched request
   op_type           op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [WIDTH-1:0] value_ff, value_in;

   // list state
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] cursor_ff, cursor_in;

   // result being built
   status_type       res_status_ff, res_status_in;
   logic [31:0]      res_read_ff, res_read_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ram port
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [WIDTH-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [WIDTH-1:0] ram_rdata;

   // index check
   resolve_type res;
   logic        allow_end;

   // shared shift step: one neighbor step and its end test
   logic [LEN_W-1:0] step;
   logic             more;
   logic             is_insert;
   logic             not_full;

   ilws_resolve u_resolve (
      .idx       (idx_ff),
      .length    (length_ff),
      .allow_end (allow_end),
      .res       (res)
   );

   ilws_ram #(
      .DATA_W (WIDTH),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_insert = (op_ff == OP_INSERT);
   assign allow_end = is_insert;
   assign not_full  = (length_ff < LEN_W'(DEPTH));

   // insert walks down from the old end, remove walks up from the position
   assign step = is_insert ? (cursor_ff - LEN_W'(1)) : (cursor_ff + LEN_W'(1));
   assign more = is_insert ? (cursor_ff > pos_ff) : (step < length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      cursor_ff     <= cursor_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      length_in     = length_ff;
      pos_in        = pos_ff;
      cursor_in     = cursor_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_we        = 1'b0;
      ram_waddr     = cursor_ff[AW-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = step[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser[2:0]);
               idx_in   = req_tdata[IDX_W-1:0];
               value_in = fit_entry(req_tdata[IDX_W+31:IDX_W]);
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_status_in = STAT_OK;
            res_read_in   = '0;
            pos_in        = res.pos;
            state_in      = ST_FINISH;
            case (op_ff)
               OP_GET: begin
                  if (res.ok) begin
                     ram_raddr = res.pos[AW-1:0];
                     state_in  = ST_READ;
                  end else begin
                     res_status_in = STAT_RANGE;
                  end
               end
               OP_SET: begin
                  if (res.ok) begin
                     ram_we    = 1'b1;
                     ram_waddr = res.pos[AW-1:0];
                     ram_wdata = value_ff;
                  end else begin
                     res_status_in = STAT_RANGE;
                  end
               end
               OP_APPEND: begin
                  if (not_full) begin
                     ram_we    = 1'b1;
                     ram_waddr = length_ff[AW-1:0];
                     ram_wdata = value_ff;
                     length_in = length_ff + LEN_W'(1);
                  end else begin
                     res_status_in = STAT_FULL;
                  end
               end
               OP_INSERT: begin
                  // index is checked before fullness
                  if (!res.ok) begin
                     res_status_in = STAT_RANGE;
                  end else if (!not_full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     cursor_in = length_ff;
                     state_in  = ST_SHIFT_RD;
                  end
               end
               OP_REMOVE: begin
                  if (res.ok) begin
                     cursor_in = res.pos;
                     state_in  = ST_SHIFT_RD;
                  end else begin
                     res_status_in = STAT_RANGE;
                  end
               end
               OP_CLEAR: begin
                  length_in = '0;
               end
               default: begin
                  // unused codes leave the list alone
               end
            endcase
         end

         ST_READ: begin
            res_read_in = fit_word(ram_rdata);
            state_in    = ST_FINISH;
         end

         ST_SHIFT_RD: begin
            if (more) begin
               // fetch the neighbor that moves into the cursor slot
               ram_raddr = step[AW-1:0];
               state_in  = ST_SHIFT_WR;
            end else if (is_insert) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff[AW-1:0];
               ram_wdata = value_ff;
               length_in = length_ff + LEN_W'(1);
               state_in  = ST_FINISH;
            end else begin
               length_in = length_ff - LEN_W'(1);
               state_in  = ST_FINISH;
            end
         end

         ST_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff[AW-1:0];
            ram_wdata = ram_rdata;
            cursor_in = step;
            state_in  = ST_SHIFT_RD;
         end

         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, fit_count(length_ff), res_read_ff, res_status_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/ilws_checker.sv
// ----------------------------------------------------------------------------
// ilws_checker
// port level checks of the indexed list with shift, bound to the top level
// ----------------------------------------------------------------------------
module ilws_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ilws_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ilws_pkg::*;

   logic [1:0]  rsp_status;
   logic [31:0] rsp_read;
   logic [4:0]  rsp_count;

   assign rsp_status = rsp_tdata[RSP_STAT_LSB+1:RSP_STAT_LSB];
   assign rsp_read   = rsp_tdata[RSP_READ_LSB+31:RSP_READ_LSB];
   assign rsp_count  = rsp_tdata[RSP_COUNT_LSB+4:RSP_COUNT_LSB];

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // one request at a time: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in work");

   // the length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_count) <= 32'(DEPTH))
      else $error("count above capacity");

   // a refused request reads nothing
   a_fail_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != STAT_OK) |-> rsp_read == 32'd0)
      else $error("read value on a refused request");

   // status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_RANGE) ||
                     (rsp_status == STAT_FULL))
      else $error("undefined status code");

endmodule

bind indexed_list_with_shift ilws_checker u_ilws_checker (.*);
